### rtl/core/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// shared constants, beat types and controller/datapath interface structs
// for the swap slot allocator
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  // field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int COUNT_W  = 11;
  localparam int ADDR_W   = 13;
  localparam int XFER_W   = 2;
  localparam int STATUS_W = 2;

  // free map organization: rows of bits
  localparam int ROW_BITS  = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
  localparam int ROWS      = MAX_SLOTS / ROW_BITS;
  localparam int BIT_W     = $clog2(ROW_BITS);
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SEC_W     = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // transfer codes
  localparam logic [XFER_W-1:0] XFER_NONE  = 2'd0;
  localparam logic [XFER_W-1:0] XFER_WRITE = 2'd1;
  localparam logic [XFER_W-1:0] XFER_READ  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  // kind of beat the datapath builds
  localparam logic [1:0] BEAT_SECTOR = 2'd0;
  localparam logic [1:0] BEAT_NOFREE = 2'd1;
  localparam logic [1:0] BEAT_RANGE  = 2'd2;
  localparam logic [1:0] BEAT_ACK    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot_index;
  } in_beat_t;

  typedef struct packed {
    logic [XFER_W-1:0]   transfer;
    logic [ADDR_W-1:0]   sector_address;
    logic [SLOT_W-1:0]   slot_granted;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic       load;
    logic       rd_row;
    logic       wr_row;
    logic       emit;
    logic [1:0] kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             row_ok;
    logic             in_range;
    logic             bit_found;
    logic             out_free;
    logic             sec_last;
  } dp_status_t;

endpackage

### rtl/core/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl
// command sequencer: latch, row read, row update, beat emission
// ----------------------------------------------------------------------------
module ssa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssa_pkg::dp_status_t status,
  output ssa_pkg::dp_cmd_t    cmd
);
  import ssa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_SINGLE = 3'd3;
  localparam logic [2:0] S_SECTOR = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] kind;
  logic [1:0] kind_next;

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        priority if (status.cmd == CMD_ALLOC) begin
          if (status.row_ok) begin
            cmd.rd_row = 1'b1;
            state_next = S_EVAL;
          end else begin
            kind_next  = BEAT_NOFREE;
            state_next = S_SINGLE;
          end
        end else if (status.cmd == CMD_READ || status.cmd == CMD_FREE) begin
          if (status.in_range) begin
            cmd.rd_row = 1'b1;
            state_next = S_EVAL;
          end else begin
            kind_next  = BEAT_RANGE;
            state_next = S_SINGLE;
          end
        end else begin
          // unknown command: no beat
          state_next = S_IDLE;
        end
      end
      S_EVAL: begin
        priority if (status.cmd == CMD_ALLOC) begin
          if (status.bit_found) begin
            cmd.wr_row = 1'b1;
            state_next = S_SECTOR;
          end else begin
            kind_next  = BEAT_NOFREE;
            state_next = S_SINGLE;
          end
        end else begin
          cmd.wr_row = 1'b1;
          if (status.cmd == CMD_READ) begin
            state_next = S_SECTOR;
          end else begin
            kind_next  = BEAT_ACK;
            state_next = S_SINGLE;
          end
        end
      end
      S_SINGLE: begin
        cmd.kind = kind;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SECTOR: begin
        cmd.kind = BEAT_SECTOR;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.sec_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= BEAT_SECTOR;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

### rtl/core/ssa_datapath.sv
// ----------------------------------------------------------------------------
// ssa_datapath
// free map rows, row summary, slot count register and output register
// ----------------------------------------------------------------------------
module ssa_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [10:0]         cfg_data,
  input  ssa_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssa_pkg::out_beat_t  out_data,
  input  ssa_pkg::dp_cmd_t    cmd,
  output ssa_pkg::dp_status_t status
);
  import ssa_pkg::*;

  logic [COUNT_W-1:0]   slot_count;
  logic [COUNT_W-1:0]   eff_n;
  logic [CMD_W-1:0]     cmd_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [SEC_W-1:0]     sec_cnt;

  // free map: a row that was never written reads as all free
  logic [ROW_BITS-1:0]  mem [ROWS];
  logic [ROW_BITS-1:0]  mem_q;
  logic                 rd_valid_q;
  logic [ROWS-1:0]      row_valid;
  logic [ROWS-1:0]      row_any;
  logic [ROW_IDX_W-1:0] r_q;

  logic [ROW_IDX_W-1:0] first_row;
  logic                 any_free;
  logic [ROW_IDX_W-1:0] rd_addr;
  logic [ROW_BITS-1:0]  word;
  logic [ROW_BITS-1:0]  allowed;
  logic [COUNT_W-1:0]   limit;
  logic [BIT_W-1:0]     found_bit;
  logic                 bit_found;
  logic [ROW_BITS-1:0]  new_word;
  logic                 out_free;
  logic                 sec_last;
  out_beat_t            beat;

  assign eff_n = (slot_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : slot_count;

  // lowest row that holds a free bit
  always_comb begin
    first_row = '0;
    any_free  = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (row_any[i]) begin
        first_row = ROW_IDX_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  assign rd_addr = (cmd_q == CMD_ALLOC) ? first_row : idx_q[SLOT_W-1:BIT_W];
  assign word    = rd_valid_q ? mem_q : '1;

  // only bits of slots below the effective count may be granted
  assign limit = eff_n - COUNT_W'({r_q, {BIT_W{1'b0}}});

  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      allowed[b] = word[b] && (COUNT_W'(b) < limit);
    end
  end

  always_comb begin
    found_bit = '0;
    bit_found = 1'b0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (allowed[b]) begin
        found_bit = BIT_W'(b);
        bit_found = 1'b1;
      end
    end
  end

  assign new_word = (cmd_q == CMD_ALLOC) ? (word & ~(ROW_BITS'(1) << found_bit))
                                         : (word | (ROW_BITS'(1) << idx_q[BIT_W-1:0]));

  assign out_free = !out_valid || !out_stall;
  assign sec_last = (sec_cnt == SEC_W'(SECTORS_PER_SLOT - 1));

  assign status.cmd       = cmd_q;
  assign status.row_ok    = any_free &&
                            (COUNT_W'({first_row, {BIT_W{1'b0}}}) < eff_n);
  assign status.in_range  = (COUNT_W'(idx_q) < eff_n);
  assign status.bit_found = bit_found;
  assign status.out_free  = out_free;
  assign status.sec_last  = sec_last;

  // beat builder
  always_comb begin
    beat = '0;
    unique case (cmd.kind)
      BEAT_SECTOR: begin
        beat.transfer       = (cmd_q == CMD_ALLOC) ? XFER_WRITE : XFER_READ;
        beat.sector_address = ADDR_W'(ADDR_W'(slot_q) * ADDR_W'(SECTORS_PER_SLOT))
                              + ADDR_W'(sec_cnt);
        beat.slot_granted   = slot_q;
        beat.status         = ST_OK;
        beat.last           = sec_last;
      end
      BEAT_NOFREE: begin
        beat.transfer = XFER_NONE;
        beat.status   = ST_NOFREE;
        beat.last     = 1'b1;
      end
      BEAT_RANGE: begin
        beat.transfer     = XFER_NONE;
        beat.slot_granted = idx_q;
        beat.status       = ST_RANGE;
        beat.last         = 1'b1;
      end
      BEAT_ACK: begin
        beat.transfer     = XFER_NONE;
        beat.slot_granted = idx_q;
        beat.status       = ST_OK;
        beat.last         = 1'b1;
      end
    endcase
  end

  // free map memory
  always_ff @(posedge clk) begin
    if (cmd.wr_row) begin
      mem[r_q] <= new_word;
    end
    if (cmd.rd_row) begin
      mem_q <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_data.cmd;
      idx_q  <= in_data.slot_index;
      slot_q <= in_data.slot_index;
    end else if (cmd.wr_row && cmd_q == CMD_ALLOC) begin
      slot_q <= SLOT_W'({r_q, found_bit});
    end
    if (cmd.rd_row) begin
      r_q        <= rd_addr;
      rd_valid_q <= row_valid[rd_addr];
    end
    if (cmd.emit) begin
      out_data <= beat;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_W'(1024);
      row_valid  <= '0;
      row_any    <= '1;
      sec_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        slot_count <= cfg_data;
      end
      if (cmd.wr_row) begin
        row_valid[r_q] <= 1'b1;
        row_any[r_q]   <= |new_word;
      end
      if (cmd.load) begin
        sec_cnt <= '0;
      end else if (cmd.emit && cmd.kind == BEAT_SECTOR) begin
        sec_cnt <= sec_cnt + SEC_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("beat loaded while output register blocked");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_row |-> $past(cmd.rd_row))
    else $error("row write without preceding row read");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.last)
    else $error("error beat not marked last");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.transfer == XFER_WRITE) |->
      (COUNT_W'(out_data.slot_granted) < eff_n))
    else $error("granted slot beyond slot count");
`endif

endmodule

### rtl/core/swap_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator_core
// first-fit swap slot allocator over a bitmap free map, one command at a time
// ----------------------------------------------------------------------------
// allocate / read-back: row read, row update, then 8 sector beats
// free: row read, row update, then one ack beat; range or no-free error: one
//   error beat; unknown cmd: no beat
// rate set by the single row read and update; one beat per cycle unless stalled
// reset: slot_count 1024, all row valid flags cleared so the whole free map
//   reads as free at once; no clearing pass
module swap_slot_allocator_core (
  input  logic               clk,
  input  logic               rst,
  // configuration: slot_count
  input  logic               cfg_write,
  input  logic [10:0]        cfg_data,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  ssa_pkg::in_beat_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output ssa_pkg::out_beat_t out_data
);
  import ssa_pkg::*;

  // controller to datapath commands and datapath status back
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer: accept, row read, row update, then beats
  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // free map rows with per-row summary bits, output register
  ssa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

endmodule
